[rtl/lms_pkg.sv]
// ----------------------------------------------------------------------------
// lms_pkg
// Types, widths, codes and saturation helpers for the LMS adaptive FIR.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 24;
    localparam int STEP_W   = 16;
    localparam int WIDX_W   = 4;
    // shared multiplier: 33-bit signed by 16-bit signed
    localparam int MUL_A_W  = 33;
    localparam int MUL_P_W  = MUL_A_W + SAMPLE_W;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [WEIGHT_W-1:0] t_weight;
    typedef logic signed [MUL_A_W-1:0]  t_mul_a;
    typedef logic signed [MUL_P_W-1:0]  t_mul_p;

    function automatic t_sample sat_sample(input logic signed [SAMPLE_W:0] v);
        t_sample r;
        if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
            r = v[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_weight sat_weight(input logic signed [WEIGHT_W:0] v);
        t_weight r;
        if (v[WEIGHT_W] != v[WEIGHT_W-1]) begin
            r = v[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            r = v[WEIGHT_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/lms_adaptive_fir.sv]
// ----------------------------------------------------------------------------
// lms_adaptive_fir
// Streaming LMS adaptive FIR filter with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_stall    action, start_run, noisy, desired, index
//  out      output     o_out_valid / i_out_stall  filtered, error, warming_up, weight
//  cfg      input      i_cfg_valid / o_cfg_ready  step size (Q0.16)
//
//  adapting sample: states PRED, DRAIN, ROUND, ERR, MUE, UPD and LAST, then DONE,
//  as the one 33x16 multiplier walks the weight and history rings twice
//  weight read: state READ (one rotation of the weight ring), then DONE; warm-up: DONE only
//  one transaction in work at a time; o_in_stall is high while it runs
//  the output register frees the core, so a stalled result only blocks the next one
//  synchronous active-low reset clears weights, history, warm-up count, step = 655
// ----------------------------------------------------------------------------
module lms_adaptive_fir
    import lms_pkg::*;
#(
    parameter int TAPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_action,
    input  logic                i_start_run,
    input  logic signed [15:0]  i_noisy_sample,
    input  logic signed [15:0]  i_desired_sample,
    input  logic [WIDX_W-1:0]   i_weight_index,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_filtered_out,
    output logic signed [15:0]  o_error_out,
    output logic                o_warming_up,
    output logic signed [23:0]  o_weight_value,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [STEP_W-1:0]   i_cfg_data
);

    localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SEEN_W = $clog2(TAPS + 1);
    localparam int CMP_W  = (IDX_W > WIDX_W) ? IDX_W : WIDX_W;
    // 40-bit products summed over TAPS, plus a sign margin
    localparam int ACC_W  = 2 * SAMPLE_W + WEIGHT_W - SAMPLE_W + 1 + $clog2(TAPS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TAPS - 1);
    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(TAPS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRED  = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_ROUND = 4'd3;
    localparam logic [3:0] S_ERR   = 4'd4;
    localparam logic [3:0] S_MUE   = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_LAST  = 4'd7;
    localparam logic [3:0] S_READ  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]         r_state;
    logic [IDX_W-1:0]   r_cnt;
    logic [SEEN_W-1:0]  r_seen;
    logic [STEP_W-1:0]  r_step;

    t_weight            r_w [TAPS];
    t_sample            r_h [TAPS];

    logic               r_action;
    logic               r_warm;
    t_sample            r_x;
    t_sample            r_d;
    logic [WIDX_W-1:0]  r_widx;

    t_mul_p             r_prod;
    logic signed [ACC_W-1:0] r_acc;
    t_sample            r_y;
    t_sample            r_e;
    t_mul_a             r_mue;
    t_weight            r_wv;

    logic               r_ovalid;
    t_sample            r_oy;
    t_sample            r_oe;
    logic               r_owarm;
    t_weight            r_owv;

    logic               in_accept;
    logic               out_free;
    logic               warm_now;
    t_mul_a             mul_a;
    t_sample            mul_b;
    t_mul_p             mul_p;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [SAMPLE_W:0]  y_clip;
    logic signed [SAMPLE_W:0]  err_wide;
    t_mul_p             upd_rnd;
    logic signed [WEIGHT_W:0]  w_sum;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ovalid || !i_out_stall;
    assign warm_now    = i_start_run || (r_seen < SEEN_FULL);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = r_h[0];
        case (r_state)
            S_PRED: mul_a = t_mul_a'(r_w[0]);
            S_MUE: begin
                mul_a = t_mul_a'($signed({1'b0, r_step}));
                mul_b = r_e;
            end
            S_UPD:  mul_a = r_mue;
            default: mul_a = '0;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // round to nearest Q.15, then clip to 17 bits before final saturation
    always_comb begin
        acc_rnd = r_acc + ACC_W'(1 << 19);
        if (acc_rnd[ACC_W-1:35] == {(ACC_W-35){acc_rnd[ACC_W-1]}}) begin
            y_clip = acc_rnd[36:20];
        end else begin
            y_clip = acc_rnd[ACC_W-1] ? -17'sd32769 : 17'sd32768;
        end
    end

    assign err_wide = (SAMPLE_W+1)'(r_d) - (SAMPLE_W+1)'(r_y);
    assign upd_rnd  = r_prod + MUL_P_W'(1 << 24);
    assign w_sum    = (WEIGHT_W+1)'(r_w[0]) + (WEIGHT_W+1)'($signed(upd_rnd[MUL_P_W-1:25]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_seen   <= '0;
            r_step   <= STEP_RESET;
            r_ovalid <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_w[i] <= '0;
                r_h[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_action <= i_action;
                        r_warm   <= warm_now;
                        r_x      <= i_noisy_sample;
                        r_d      <= i_desired_sample;
                        r_widx   <= i_weight_index;
                        r_cnt    <= '0;
                        r_y      <= '0;
                        r_e      <= '0;
                        r_wv     <= '0;
                        r_acc    <= '0;
                        r_prod   <= '0;
                        if (i_start_run) begin
                            for (int i = 0; i < TAPS; i++) begin
                                r_w[i] <= '0;
                            end
                        end
                        if (i_action == ACT_READ) begin
                            // a restart on a read clears history and count too
                            if (i_start_run) begin
                                r_seen <= '0;
                                for (int i = 0; i < TAPS; i++) begin
                                    r_h[i] <= '0;
                                end
                            end
                            r_state <= S_READ;
                        end else if (warm_now) begin
                            // warm-up: store the sample only
                            r_seen <= i_start_run ? SEEN_W'(1) : r_seen + 1'b1;
                            for (int i = TAPS - 1; i > 0; i--) begin
                                r_h[i] <= i_start_run ? '0 : r_h[i-1];
                            end
                            r_h[0]  <= i_noisy_sample;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_PRED;
                        end
                    end
                end
                S_PRED: begin
                    r_prod <= mul_p;
                    r_acc  <= r_acc + $signed(r_prod[ACC_W-1:0]);
                    for (int i = 0; i < TAPS - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                        r_h[i] <= r_h[i+1];
                    end
                    r_w[TAPS-1] <= r_w[0];
                    r_h[TAPS-1] <= r_h[0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_acc   <= r_acc + $signed(r_prod[ACC_W-1:0]);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_y     <= sat_sample(y_clip);
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_e     <= sat_sample(err_wide);
                    r_state <= S_MUE;
                end
                S_MUE: begin
                    r_mue   <= mul_p[MUL_A_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    // weight ring lags the history ring by one tap
                    r_prod <= mul_p;
                    for (int i = 0; i < TAPS - 1; i++) begin
                        r_h[i] <= r_h[i+1];
                    end
                    r_h[TAPS-1] <= r_h[0];
                    if (r_cnt != '0) begin
                        for (int i = 0; i < TAPS - 1; i++) begin
                            r_w[i] <= r_w[i+1];
                        end
                        r_w[TAPS-1] <= sat_weight(w_sum);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    for (int i = 0; i < TAPS - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[TAPS-1] <= sat_weight(w_sum);
                    for (int i = TAPS - 1; i > 0; i--) begin
                        r_h[i] <= r_h[i-1];
                    end
                    r_h[0]  <= r_x;
                    r_state <= S_DONE;
                end
                S_READ: begin
                    if (CMP_W'(r_cnt) == CMP_W'(r_widx)) begin
                        r_wv <= r_w[0];
                    end
                    for (int i = 0; i < TAPS - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[TAPS-1] <= r_w[0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_oy     <= r_y;
                        r_oe     <= r_e;
                        r_owarm  <= r_warm;
                        r_owv    <= (r_action == ACT_READ) ? r_wv : '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_filtered_out = r_oy;
    assign o_error_out    = r_oe;
    assign o_warming_up   = r_owarm;
    assign o_weight_value = r_owv;

    // warm-up count saturates at the tap count
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_FULL)
        else $error("warm-up count beyond tap count");

    // warm-up results carry no prediction
    a_warm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_warming_up) |-> (o_filtered_out == '0 && o_error_out == '0))
        else $error("nonzero prediction during warm-up");

    // prediction pass steps one tap per cycle
    a_pred_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRED && r_cnt != LAST_IDX) |=>
        (r_state == S_PRED && r_cnt == $past(r_cnt) + 1'b1))
        else $error("prediction pass skipped a tap");

    // an accepted transaction always leaves idle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted transaction dropped");

endmodule
